// ===== hw/rtl/msadpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// msadpcm_pkg
// Shared types and constants for the block-based ADPCM decoder.
// ----------------------------------------------------------------------------
package msadpcm_pkg;

    // Input transaction: one encoded byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_restart;
    } in_item_t;

    // Result transaction: one PCM sample
    typedef struct packed {
        logic signed [15:0] sample_value;
        logic               channel_index;
        logic               last_of_run;
    } out_item_t;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_FIELD  = 2'd2,
        CMD_DATA   = 2'd3
    } cmd_kind_t;

    // Header field selector
    typedef enum logic [1:0] {
        FLD_STEP  = 2'd0,
        FLD_S1    = 2'd1,
        FLD_S2    = 2'd2
    } field_sel_t;

    // Command word in the front-to-back queue
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data_byte;
        logic [7:0]  low_byte;
        field_sel_t  field;
        logic        ch;
        logic        hdr_last;
        logic        stereo;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_BASE1  = 3'd1,
        BK_BASE2  = 3'd2,
        BK_SAMP   = 3'd3,
        BK_STEP   = 3'd4,
        BK_EMIT   = 3'd5,
        BK_HDR    = 3'd6
    } bk_state_t;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_STEREO = 1'd0;
    localparam logic [0:0] REG_BLOCK  = 1'd1;

    localparam logic [15:0] BLOCK_RESET = 16'd512;

    // Step adaptation table
    function automatic logic [9:0] adapt_lut(input logic [3:0] nib);
        logic [9:0] r;
        case (nib)
            4'd4, 4'd12:  r = 10'd307;
            4'd5, 4'd11:  r = 10'd409;
            4'd6, 4'd10:  r = 10'd512;
            4'd7, 4'd9:   r = 10'd614;
            4'd8:         r = 10'd768;
            default:      r = 10'd230;
        endcase
        return r;
    endfunction

    // First predictor coefficient (512 needs the eleventh bit)
    function automatic logic signed [10:0] coef_a_lut(input logic [2:0] idx);
        logic signed [10:0] r;
        case (idx)
            3'd0:    r = 11'sd256;
            3'd1:    r = 11'sd512;
            3'd2:    r = 11'sd0;
            3'd3:    r = 11'sd192;
            3'd4:    r = 11'sd240;
            3'd5:    r = 11'sd460;
            default: r = 11'sd392;
        endcase
        return r;
    endfunction

    // Second predictor coefficient
    function automatic logic signed [10:0] coef_b_lut(input logic [2:0] idx);
        logic signed [10:0] r;
        case (idx)
            3'd1:    r = -11'sd256;
            3'd3:    r = 11'sd64;
            3'd5:    r = -11'sd208;
            3'd6:    r = -11'sd232;
            default: r = 11'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/msadpcm_front.sv =====
// ----------------------------------------------------------------------------
// msadpcm_front
// Tracks the byte position within a block and classifies each byte.
// ----------------------------------------------------------------------------
module msadpcm_front
    import msadpcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stereo_mode,
    input  logic [15:0] block_bytes,
    input  logic        in_valid,
    input  in_item_t    in_item,
    output logic        cmd_valid,
    output cmd_t        cmd
);

    logic [15:0] pos_reg, pos_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] p;
    logic [15:0] p1;
    logic [4:0]  hdr;
    logic [3:0]  q;
    logic        short_blk;

    // Position and classification
    always_comb
    begin
        hdr       = stereo_mode ? 5'd14 : 5'd7;
        p         = (in_item.stream_restart || pos_reg >= block_bytes) ? 16'd0 : pos_reg;
        short_blk = block_bytes < {11'd0, hdr};
        p1        = p + 16'd1;
        q         = p[3:0] - (stereo_mode ? 4'd2 : 4'd1);
        pos_next  = pos_reg;
        low_next  = low_reg;
        cmd       = '0;
        cmd.data_byte = in_item.data_byte;
        cmd.low_byte  = low_reg;
        cmd.stereo    = stereo_mode;
        cmd.kind      = CMD_NONE;
        if (in_valid)
        begin
            if (short_blk)
                pos_next = 16'd0;
            else
            begin
                pos_next = (p1 >= block_bytes) ? 16'd0 : p1;
                if (p < (stereo_mode ? 16'd2 : 16'd1))
                begin
                    cmd.kind = CMD_COEF;
                    cmd.ch   = p[0];
                end
                else if (p < {11'd0, hdr})
                begin
                    cmd.kind     = CMD_FIELD;
                    cmd.hdr_last = (p == {11'd0, hdr} - 16'd1);
                    if (stereo_mode)
                    begin
                        cmd.ch    = q[1];
                        cmd.field = (q < 4'd4) ? FLD_STEP : (q < 4'd8) ? FLD_S1 : FLD_S2;
                        if (!q[0]) low_next = in_item.data_byte;
                    end
                    else
                    begin
                        cmd.ch    = 1'b0;
                        cmd.field = (q < 4'd2) ? FLD_STEP : (q < 4'd4) ? FLD_S1 : FLD_S2;
                        if (!q[0]) low_next = in_item.data_byte;
                    end
                    if (!q[0]) cmd.field = FLD_STEP;
                    if (!q[0]) cmd.kind = cmd.hdr_last ? CMD_FIELD : CMD_NONE;
                end
                else
                    cmd.kind = CMD_DATA;
            end
        end
    end

    assign cmd_valid = in_valid && (cmd.kind != CMD_NONE);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            low_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            low_reg <= low_next;
        end
    end

endmodule

// ===== hw/rtl/msadpcm_queue.sv =====
// ----------------------------------------------------------------------------
// msadpcm_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module msadpcm_queue
    import msadpcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd,
    output logic empty,
    output cmd_t rd_data
);

    cmd_t       mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rp_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// ===== hw/rtl/msadpcm_back.sv =====
// ----------------------------------------------------------------------------
// msadpcm_back
// Executes header writes, emits the header seed samples and expands nibbles over one shared multiplier.
// ----------------------------------------------------------------------------
module msadpcm_back
    import msadpcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_empty,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      res_valid,
    output out_item_t res,
    input  logic      res_ready
);

    bk_state_t state_reg, state_next;
    logic signed [10:0] c1_reg [2];
    logic signed [10:0] c2_reg [2];
    logic signed [31:0] step_reg [2];
    logic signed [15:0] s1_reg [2];
    logic signed [15:0] s2_reg [2];
    logic signed [31:0] acc_reg, acc_next;
    logic               half_reg, half_next;
    logic [1:0]         emit_reg, emit_next;
    logic               ch;
    logic [3:0]         nib;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic signed [31:0] base;
    logic signed [35:0] psum;
    logic signed [15:0] pclamp;
    logic signed [63:0] dsc;
    logic signed [31:0] dnew;
    logic signed [15:0] fval;

    // Current nibble and channel
    assign nib = half_reg ? cmd.data_byte[3:0] : cmd.data_byte[7:4];
    assign ch  = half_reg ? cmd.stereo : 1'b0;
    assign fval = {cmd.data_byte, cmd.low_byte};

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        unique case (state_reg)
            BK_BASE1:
            begin
                mul_a = 32'(s1_reg[ch]);
                mul_b = 32'(c1_reg[ch]);
            end
            BK_BASE2:
            begin
                mul_a = 32'(s2_reg[ch]);
                mul_b = 32'(c2_reg[ch]);
            end
            BK_SAMP:
            begin
                mul_a = step_reg[ch];
                mul_b = 32'(signed'(nib));
            end
            BK_STEP:
            begin
                mul_a = step_reg[ch];
                mul_b = {22'd0, adapt_lut(nib)};
            end
            default: ;
        endcase
        prod = mul_a * mul_b;
    end

    // Prediction and step arithmetic
    always_comb
    begin
        base = (acc_reg < 0) ? -((-acc_reg) >>> 8) : (acc_reg >>> 8);
        psum = 36'(base) + 36'(prod);
        if (psum < -36'sd32768)     pclamp = -16'sd32768;
        else if (psum > 36'sd32767) pclamp = 16'sd32767;
        else                        pclamp = psum[15:0];
        dsc = (prod < 0) ? -((-prod) >>> 8) : (prod >>> 8);
        if (dsc < 64'sd16)                dnew = 32'sd16;
        else if (dsc > 64'sh7FFFFFFF)     dnew = 32'sh7FFFFFFF;
        else                              dnew = dsc[31:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!cmd_empty)
                begin
                    if (cmd.kind == CMD_DATA) state_next = BK_BASE1;
                    else if (cmd.kind == CMD_FIELD && cmd.hdr_last) state_next = BK_HDR;
                end
            BK_BASE1: state_next = BK_BASE2;
            BK_BASE2: state_next = BK_SAMP;
            BK_SAMP:  state_next = BK_EMIT;
            BK_EMIT:  if (res_ready) state_next = BK_STEP;
            BK_STEP:  state_next = half_reg ? BK_IDLE : BK_BASE1;
            BK_HDR:
                if (res_ready && emit_reg == (cmd.stereo ? 2'd3 : 2'd1))
                    state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        cmd_pop   = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        acc_next  = acc_reg;
        half_next = half_reg;
        emit_next = emit_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                half_next = 1'b0;
                emit_next = 2'd0;
                if (!cmd_empty && !(cmd.kind == CMD_DATA)
                    && !(cmd.kind == CMD_FIELD && cmd.hdr_last))
                    cmd_pop = 1'b1;
            end
            BK_BASE1: acc_next = prod[31:0];
            BK_BASE2: acc_next = acc_reg + prod[31:0];
            BK_SAMP:  acc_next = 32'(pclamp);
            BK_EMIT:
            begin
                res_valid = 1'b1;
                res.sample_value  = acc_reg[15:0];
                res.channel_index = ch;
                res.last_of_run   = half_reg;
            end
            BK_STEP:
            begin
                half_next = 1'b1;
                if (half_reg) cmd_pop = 1'b1;
            end
            BK_HDR:
            begin
                res_valid = 1'b1;
                if (cmd.stereo)
                begin
                    res.channel_index = emit_reg[0];
                    res.sample_value  = emit_reg[1] ? s1_reg[emit_reg[0]]
                                                    : s2_reg[emit_reg[0]];
                    res.last_of_run   = emit_reg == 2'd3;
                end
                else
                begin
                    res.channel_index = 1'b0;
                    res.sample_value  = emit_reg[0] ? s1_reg[0] : s2_reg[0];
                    res.last_of_run   = emit_reg == 2'd1;
                end
                if (res_ready)
                begin
                    emit_next = emit_reg + 2'd1;
                    if (res.last_of_run) cmd_pop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            half_reg  <= 1'b0;
            emit_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
            emit_reg  <= emit_next;
        end
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            for (int i = 0; i < 2; i++)
            begin
                c1_reg[i]   <= '0;
                c2_reg[i]   <= '0;
                step_reg[i] <= '0;
                s1_reg[i]   <= '0;
                s2_reg[i]   <= '0;
            end
        end
        else
        begin
            acc_reg <= acc_next;
            if (state_reg == BK_SAMP)
            begin
                s2_reg[ch] <= s1_reg[ch];
                s1_reg[ch] <= pclamp;
            end
            if (state_reg == BK_STEP)
                step_reg[ch] <= dnew;
            if (state_reg == BK_IDLE && !cmd_empty && cmd.kind == CMD_COEF)
            begin
                c1_reg[cmd.ch] <= (cmd.data_byte > 8'd6) ? coef_a_lut(3'd6)
                                  : coef_a_lut(cmd.data_byte[2:0]);
                c2_reg[cmd.ch] <= (cmd.data_byte > 8'd6) ? coef_b_lut(3'd6)
                                  : coef_b_lut(cmd.data_byte[2:0]);
            end
            if (state_reg == BK_IDLE && !cmd_empty && cmd.kind == CMD_FIELD)
            begin
                unique case (cmd.field)
                    FLD_STEP: step_reg[cmd.ch] <= 32'(fval);
                    FLD_S1:   s1_reg[cmd.ch]   <= fval;
                    FLD_S2:   s2_reg[cmd.ch]   <= fval;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/ms_adpcm_block_decoder.sv =====
// ----------------------------------------------------------------------------
// ms_adpcm_block_decoder
// Block-based ADPCM decoder, one encoded byte per input transaction.
// ----------------------------------------------------------------------------
// Each data byte passes through the back part as a dispatch step and then two
// nibble expansions, each of four passes through the one shared multiplier plus
// an output state; a stalled output holds the expansion in that state. Header
// bytes before the last are retired at dispatch, and the last header byte is
// dispatched and then holds the back part while its two or four seed samples are
// delivered, one per cycle while the output accepts them.
// The front part runs ahead by up to two queued commands.
module ms_adpcm_block_decoder
    import msadpcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  in_item_t    in_data,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_data
);

    logic        stereo_reg;
    logic [15:0] blk_reg;
    logic        q_full, q_empty, q_pop, cmd_valid, res_valid, out_valid_reg;
    logic        res_take, acc;
    cmd_t        f_cmd, q_cmd;
    out_item_t   res, out_reg;

    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg <= 1'b0;
            blk_reg    <= BLOCK_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_STEREO && paddr[1:0] == 2'd0) stereo_reg <= pwdata[0];
            if (paddr[2] == REG_BLOCK && paddr[1:0] == 2'd0)  blk_reg    <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_STEREO && paddr[1:0] == 2'd0)     prdata = {31'd0, stereo_reg};
        else if (paddr[2] == REG_BLOCK && paddr[1:0] == 2'd0) prdata = {16'd0, blk_reg};
    end

    assign full = q_full;
    assign acc  = push && !full;

    msadpcm_front u_front (
        .clk(clk), .rst_n(rst_n), .stereo_mode(stereo_reg), .block_bytes(blk_reg),
        .in_valid(acc), .in_item(in_data), .cmd_valid(cmd_valid), .cmd(f_cmd)
    );

    msadpcm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(cmd_valid), .wr_data(f_cmd), .full(q_full),
        .rd(q_pop), .empty(q_empty), .rd_data(q_cmd)
    );

    msadpcm_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_empty(q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
        .res_valid(res_valid), .res(res), .res_ready(res_take)
    );

    // Output register
    assign res_take = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid) out_reg <= res;
    end

`ifndef NO_ASSERTIONS
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !cmd_valid) else $error("command queue overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty) else $error("command queue underflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg) else $error("result lost");
`endif

endmodule
